FILE: sv/pcr_pkg.sv
// Package for the poset closure repair block: field widths, item codes,
// controller states and the structs passed between the top level and the sweep unit.
// No dependencies.
package pcr_pkg;

  localparam int MaxEvents = 64;
  localparam int DataW     = 64;
  localparam int EvIdxW    = 6;
  localparam int ActW      = 7;
  localparam logic [ActW-1:0] ActReset = 7'd64;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_STILL  = 2'd2,
    FUNC_LOAD   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  // Start of one closure: direction, starting set and active-event mask.
  typedef struct packed {
    logic             start;
    logic             up;
    logic [DataW-1:0] seed;
    logic [DataW-1:0] mask;
  } sweep_req_t;

  // Parent row write from a load item.
  typedef struct packed {
    logic              we;
    logic [EvIdxW-1:0] addr;
    logic [DataW-1:0]  data;
  } sweep_wr_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] set;
  } sweep_rsp_t;

endpackage

FILE: sv/pcr_if.sv
// Handshake channels of the poset closure repair block: input items and result items.
// Depends on nothing; payload widths follow the fields of the block.
interface pcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  event_index;
  logic [63:0] parent_bits;
  logic [63:0] genotype_in;
  logic        compatible_mode;

  modport source (output valid, func, event_index, parent_bits, genotype_in,
                  compatible_mode, input ready);
  modport sink (input valid, func, event_index, parent_bits, genotype_in,
                compatible_mode, output ready);
endinterface

interface pcr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

FILE: sv/poset_closure_repair_core.sv
// Top level of the poset closure repair block: item handshakes, active-event register,
// move setup, result register. Depends on pcr_pkg, pcr_if and pcr_sweep.
//
//   channel   dir  handshake        payload
//   in_i      in   valid / ready    func, event_index, parent_bits, genotype_in,
//                                   compatible_mode
//   out_o     out  valid / ready    sample_out
//   cfg       in   cfg_we_i         cfg_wdata_i (active_events)
//
// A load item gives no result; a stand-still item gives the masked genotype.
// An add or remove runs P passes over the parent row memory, each pass reading
// one row per cycle; P is at most the longest chain plus one, and at most
// MAX_EVENTS + 1.
// Reset clears all parent rows at once through per-row valid bits.
// The next item is taken while the previous result waits in the output register.
module poset_closure_repair_core #(
  parameter int MAX_EVENTS = pcr_pkg::MaxEvents
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pcr_pkg::ActW-1:0]     cfg_wdata_i,
  pcr_in_if.sink                       in_i,
  pcr_out_if.source                    out_o
);
  import pcr_pkg::*;

  state_e           state_q, state_d;
  logic [ActW-1:0]  act_q;
  logic [DataW-1:0] base_q, base_d;
  logic             rem_q, rem_d;
  logic [DataW-1:0] res_q, res_d;
  logic             out_vld_q, out_vld_d;
  logic [DataW-1:0] out_data_q;

  logic [DataW-1:0] mask;
  logic [DataW-1:0] one;
  logic [DataW-1:0] g;
  logic             accept;
  logic             hold_fire;
  func_e            func;
  sweep_req_t       req;
  sweep_wr_t        wr;
  sweep_rsp_t       rsp;

  // A count of zero still enables event 0; counts above MAX_EVENTS stop there.
  always_comb begin
    for (int i = 0; i < DataW; i++) begin
      mask[i] = ((ActW'(i) < act_q) || (i == 0)) && (i < MAX_EVENTS);
    end
  end

  assign func      = func_e'(in_i.func);
  assign g         = in_i.genotype_in & mask;
  assign one       = (DataW'(1) << in_i.event_index) & mask;
  assign accept    = in_i.valid && in_i.ready;
  assign hold_fire = (state_q == ST_HOLD) && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func)
            FUNC_LOAD:  state_d = ST_IDLE;
            FUNC_STILL: state_d = ST_HOLD;
            FUNC_ADD,
            FUNC_REMOVE: state_d = ST_RUN;
          endcase
        end
      end
      ST_RUN: begin
        if (rsp.done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (hold_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Add: result is the base plus the up-closure.  Remove: the base minus the
  // down-closure; in the repair mode the seed is every missing event plus the removed one.
  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    req.start   = 1'b0;
    req.up      = 1'b1;
    req.seed    = one;
    req.mask    = mask;
    wr.we       = 1'b0;
    wr.addr     = in_i.event_index;
    wr.data     = in_i.parent_bits;
    base_d      = base_q;
    rem_d       = rem_q;
    res_d       = res_q;
    if (accept) begin
      unique case (func)
        FUNC_LOAD: begin
          wr.we = 1'b1;
        end
        FUNC_STILL: begin
          res_d = g;
        end
        FUNC_ADD: begin
          req.start = 1'b1;
          req.up    = 1'b1;
          req.seed  = in_i.compatible_mode ? one : (g | one);
          base_d    = g | one;
          rem_d     = 1'b0;
        end
        FUNC_REMOVE: begin
          req.start = 1'b1;
          req.up    = 1'b0;
          req.seed  = in_i.compatible_mode ? one : ((~g | one) & mask);
          base_d    = g;
          rem_d     = 1'b1;
        end
      endcase
    end
    if ((state_q == ST_RUN) && rsp.done) begin
      res_d = rem_q ? (base_q & ~rsp.set) : (base_q | rsp.set);
    end
    if (hold_fire) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      act_q     <= ActReset;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        act_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    if (hold_fire) begin
      out_data_q <= res_q;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_data_q;

  pcr_sweep #(
    .MAX_EVENTS(MAX_EVENTS)
  ) u_sweep (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .wr_i  (wr),
    .req_i (req),
    .rsp_o (rsp)
  );

endmodule

FILE: sv/pcr_sweep.sv
// Sweep unit: parent row memory with per-row valid bits, and the closure engine
// that reads one row a cycle and repeats whole passes until the set stops growing.
// Depends on pcr_pkg.
module pcr_sweep #(
  parameter int MAX_EVENTS = pcr_pkg::MaxEvents
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcr_pkg::sweep_wr_t   wr_i,
  input  pcr_pkg::sweep_req_t  req_i,
  output pcr_pkg::sweep_rsp_t  rsp_o
);
  import pcr_pkg::*;

  localparam int IdxW = $clog2(MAX_EVENTS);
  localparam int CntW = $clog2(MAX_EVENTS + 1);
  localparam logic [CntW-1:0] IssEnd  = CntW'(MAX_EVENTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_EVENTS - 1);

  logic [DataW-1:0]      mem [MAX_EVENTS];
  logic [MAX_EVENTS-1:0] row_vld_q;

  logic             busy_q, busy_d;
  logic [CntW-1:0]  iss_q, iss_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic [DataW-1:0] row_q;
  logic             rowv_q;
  logic [DataW-1:0] set_q, set_d;
  logic             chg_q, chg_d;
  logic             up_q;
  logic [DataW-1:0] mask_q;
  logic             done_q, done_d;

  logic             wr_ok;
  logic             issue;
  logic [DataW-1:0] row_m;
  logic [DataW-1:0] set_n;
  logic             pass_chg;

  assign wr_ok = wr_i.we && (32'(wr_i.addr) < MAX_EVENTS);
  assign issue = busy_q && (iss_q != IssEnd);

  // Rows are only ever written while no closure runs, so reads need no forwarding.
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[wr_i.addr[IdxW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      row_q <= mem[iss_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rowv_q    <= 1'b0;
    end else begin
      if (wr_ok) begin
        row_vld_q[wr_i.addr[IdxW-1:0]] <= 1'b1;
      end
      if (issue) begin
        rowv_q <= row_vld_q[iss_q[IdxW-1:0]];
      end
    end
  end

  // A row never loaded since reset reads as no parents.
  assign row_m = (rowv_q ? row_q : '0) & mask_q;

  always_comb begin
    set_n = set_q;
    if (rd_vld_q) begin
      if (up_q) begin
        if (set_q[rd_idx_q]) begin
          set_n = set_q | row_m;
        end
      end else if (mask_q[rd_idx_q] && ((row_m & set_q) != '0)) begin
        set_n[rd_idx_q] = 1'b1;
      end
    end
  end

  assign pass_chg = chg_q || (set_n != set_q);

  always_comb begin
    busy_d   = busy_q;
    iss_d    = iss_q;
    rd_vld_d = issue;
    rd_idx_d = rd_idx_q;
    set_d    = set_n;
    chg_d    = chg_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      busy_d   = 1'b1;
      iss_d    = '0;
      rd_vld_d = 1'b0;
      set_d    = req_i.seed & req_i.mask;
      chg_d    = 1'b0;
    end else if (busy_q) begin
      if (issue) begin
        iss_d    = iss_q + 1'b1;
        rd_idx_d = iss_q[IdxW-1:0];
      end
      if (rd_vld_q) begin
        chg_d = pass_chg;
        if (rd_idx_q == LastIdx) begin
          // End of a pass: run another one unless the set stayed the same.
          if (pass_chg) begin
            iss_d = '0;
            chg_d = 1'b0;
          end else begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      iss_q    <= '0;
      rd_vld_q <= 1'b0;
      chg_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      iss_q    <= iss_d;
      rd_vld_q <= rd_vld_d;
      chg_q    <= chg_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    set_q    <= set_d;
    if (req_i.start) begin
      up_q   <= req_i.up;
      mask_q <= req_i.mask;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.set  = set_q;

endmodule

FILE: dv/tb_closure_pkg.sv
// Scoreboard for the poset closure repair testbench: the input item struct, a shadow copy
// of the parent rows and active count, the genotype closure predictor and expected results.
// Depends on pcr_pkg.
package tb_closure_pkg;
  import pcr_pkg::*;

  localparam int ReportLimit = 10;

  typedef struct packed {
    func_e             func;
    logic [EvIdxW-1:0] idx;
    logic [DataW-1:0]  parents;
    logic [DataW-1:0]  geno;
    logic              compat;
  } closure_item_t;

  class closure_scoreboard;
    logic [DataW-1:0] row_copy [MaxEvents];
    logic [ActW-1:0]  active_cnt;
    logic [DataW-1:0] expected_genotypes [$];
    int unsigned      error_count;

    function new();
      foreach (row_copy[v]) row_copy[v] = '0;
      active_cnt  = ActReset;
      error_count = 0;
    endfunction

    function void set_active(logic [ActW-1:0] value);
      active_cnt = value;
    endfunction

    function int pending();
      return expected_genotypes.size();
    endfunction

    // A count of zero acts as one event, a count above the event limit as the limit.
    function logic [DataW-1:0] active_mask();
      int n;
      n = int'(active_cnt);
      if (n < 1) n = 1;
      if (n > MaxEvents) n = MaxEvents;
      if (n >= DataW) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    function logic [DataW-1:0] row_union(logic [DataW-1:0] nodes, logic [DataW-1:0] mask);
      logic [DataW-1:0] acc;
      acc = '0;
      for (int v = 0; v < MaxEvents; v++)
        if (nodes[v]) acc |= row_copy[v];
      return acc & mask;
    endfunction

    // Active nodes with at least one active parent among the given nodes.
    function logic [DataW-1:0] child_set(logic [DataW-1:0] nodes, logic [DataW-1:0] mask);
      logic [DataW-1:0] acc;
      acc = '0;
      for (int v = 0; v < MaxEvents; v++)
        if (mask[v] && (row_copy[v] & mask & nodes) != '0) acc[v] = 1'b1;
      return acc;
    endfunction

    function logic [DataW-1:0] ancestor_close(logic [DataW-1:0] nodes,
                                              logic [DataW-1:0] mask);
      logic [DataW-1:0] grown;
      grown = nodes | row_union(nodes, mask);
      while (grown != nodes) begin
        nodes = grown;
        grown = nodes | row_union(nodes, mask);
      end
      return nodes;
    endfunction

    function logic [DataW-1:0] descendant_close(logic [DataW-1:0] nodes,
                                                logic [DataW-1:0] mask);
      logic [DataW-1:0] grown;
      grown = nodes | child_set(nodes, mask);
      while (grown != nodes) begin
        nodes = grown;
        grown = nodes | child_set(nodes, mask);
      end
      return nodes;
    endfunction

    // Applies one item to the shadow state; returns 1 when the item yields a genotype.
    function bit predict_genotype(closure_item_t it, output logic [DataW-1:0] genotype);
      logic [DataW-1:0] mask, g, one, pruned;
      mask     = active_mask();
      g        = it.geno & mask;
      one      = (64'd1 << it.idx) & mask;
      genotype = '0;
      case (it.func)
        FUNC_LOAD: begin
          row_copy[it.idx] = it.parents;
          return 1'b0;
        end
        FUNC_ADD: begin
          if (it.compat) g = g | one | ancestor_close(one, mask);
          else g = ancestor_close(g | one, mask);
        end
        FUNC_REMOVE: begin
          g &= ~one;
          if (it.compat) begin
            g &= ~descendant_close(one, mask);
          end else begin
            // Drop every event that has a missing parent until nothing changes.
            pruned = g & ~child_set(~g & mask, mask);
            while (pruned != g) begin
              g      = pruned;
              pruned = g & ~child_set(~g & mask, mask);
            end
          end
        end
        default: ;
      endcase
      genotype = g & mask;
      return 1'b1;
    endfunction

    function void note_input(closure_item_t it);
      logic [DataW-1:0] genotype;
      if (predict_genotype(it, genotype)) expected_genotypes.push_back(genotype);
    endfunction

    function void check_result(logic [DataW-1:0] got);
      logic [DataW-1:0] want;
      if (expected_genotypes.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("tb_top: sample_out %h arrived with nothing expected", got);
        return;
      end
      want = expected_genotypes.pop_front();
      if (got !== want) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("tb_top: sample_out mismatch, expected %h, got %h", want, got);
      end
    endfunction
  endclass

endpackage

FILE: dv/tb_top.sv
// Top of the poset closure repair testbench: clock, reset, a sender that works in bursts,
// a stalling receiver, the watchdog and the directed and random item sequences.
// Depends on pcr_pkg, pcr_if, tb_closure_pkg and poset_closure_repair_core.
module tb_top;
  import pcr_pkg::*;
  import tb_closure_pkg::*;

  localparam int HalfPeriod   = 4;
  localparam int ResetCycles  = 9;
  localparam int IdleLimit    = 40000;
  localparam int LongHold     = 2500;
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 100;

  typedef enum int {GRAPH_KEEP, GRAPH_LAYERED, GRAPH_CHAIN, GRAPH_TANGLED} graph_kind_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} stall_mode_e;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic [ActW-1:0] cfg_wdata;

  pcr_in_if  in_ch ();
  pcr_out_if out_ch ();

  poset_closure_repair_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  closure_scoreboard sb = new();

  graph_kind_e graph_kind   = GRAPH_LAYERED;
  int          node_level [MaxEvents];
  int          edge_odds    = 4;
  int          active_n     = MaxEvents;
  int          burst_left   = 0;
  bit          sender_eager = 1'b0;
  int          hold_asked   = 0;

  always #(HalfPeriod) clk = ~clk;

  function automatic logic [DataW-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic closure_item_t make_item(func_e f, logic [EvIdxW-1:0] idx,
                                              logic [DataW-1:0] parents,
                                              logic [DataW-1:0] geno, logic compat);
    closure_item_t it;
    it.func    = f;
    it.idx     = idx;
    it.parents = parents;
    it.geno    = geno;
    it.compat  = compat;
    return it;
  endfunction

  // Parent row of node v in the current graph. Bits of inactive events get random
  // values, since the block has to mask them off when it reads the row.
  function automatic logic [DataW-1:0] make_row(int v);
    logic [DataW-1:0] row;
    row = '0;
    for (int u = 0; u < MaxEvents; u++) begin
      if (u >= active_n) begin
        row[u] = ($urandom_range(0, 7) == 0);
      end else begin
        case (graph_kind)
          GRAPH_CHAIN:   row[u] = (u == v - 1) || (u < v - 1 && $urandom_range(0, 15) == 0);
          GRAPH_TANGLED: row[u] = ($urandom_range(0, edge_odds * 4) == 0);
          default:       row[u] = node_level[u] < node_level[v] &&
                                  $urandom_range(0, edge_odds) == 0;
        endcase
      end
    end
    return row;
  endfunction

  // Mostly genotypes that already hold every ancestor, some of them slightly broken,
  // and some raw noise.
  function automatic logic [DataW-1:0] pick_genotype();
    logic [DataW-1:0] mask, closed;
    mask   = sb.active_mask();
    closed = sb.ancestor_close(rand_word() & rand_word() & mask, mask);
    case ($urandom_range(0, 9))
      0, 1:    return rand_word();
      2:       return '0;
      3:       return '1;
      4:       return closed ^ (64'd1 << $urandom_range(0, active_n - 1));
      5:       return closed | (rand_word() & ~mask);
      default: return closed;
    endcase
  endfunction

  function automatic closure_item_t random_item();
    closure_item_t it;
    int roll;
    roll       = $urandom_range(0, 99);
    it.parents = rand_word();
    it.geno    = rand_word();
    it.compat  = 1'($urandom_range(0, 1));
    it.idx     = EvIdxW'(($urandom_range(0, 9) != 0) ? $urandom_range(0, active_n - 1)
                                                     : $urandom_range(0, MaxEvents - 1));
    if (roll < 8) begin
      it.func = FUNC_LOAD;
      if (it.idx < active_n) it.parents = make_row(int'(it.idx));
    end else begin
      it.func = (roll < 16) ? FUNC_STILL : (roll < 58) ? FUNC_ADD : FUNC_REMOVE;
      it.geno = pick_genotype();
    end
    return it;
  endfunction

  task automatic offer(input closure_item_t it);
    int gap;
    in_ch.valid           <= 1'b1;
    in_ch.func            <= it.func;
    in_ch.event_index     <= it.idx;
    in_ch.parent_bits     <= it.parents;
    in_ch.genotype_in     <= it.geno;
    in_ch.compatible_mode <= it.compat;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
    if (!sender_eager) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40)
                                                 : $urandom_range(0, 4);
        burst_left = $urandom_range(0, 10);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Stops sending and waits for every expected genotype, then lets a trailing load finish.
  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [ActW-1:0] act);
    drain(SettleCycles);
    cfg_we    <= 1'b1;
    cfg_wdata <= act;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_active(act);
    active_n = (act == 0) ? 1 : (act > MaxEvents) ? MaxEvents : int'(act);
  endtask

  task automatic load_graph(input graph_kind_e kind);
    int depth;
    graph_kind = kind;
    edge_odds  = $urandom_range(1, 5);
    depth      = $urandom_range(2, 8);
    for (int v = 0; v < MaxEvents; v++)
      node_level[v] = (kind == GRAPH_CHAIN) ? v : $urandom_range(0, depth - 1);
    for (int v = 0; v < active_n; v++)
      offer(make_item(FUNC_LOAD, EvIdxW'(v), make_row(v), rand_word(),
                      1'($urandom_range(0, 1))));
    // Rows of inactive events are stored too but must never show.
    if (active_n < MaxEvents) begin
      repeat (2)
        offer(make_item(FUNC_LOAD, EvIdxW'($urandom_range(active_n, MaxEvents - 1)),
                        rand_word(), rand_word(), 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic run_phase(input logic [ActW-1:0] act, input graph_kind_e kind,
                           input int moves, input bit eager, input int hold_at,
                           input int pause_at);
    reconfigure(act);
    sender_eager = eager;
    if (kind != GRAPH_KEEP) load_graph(kind);
    for (int m = 0; m < moves; m++) begin
      if (m == hold_at) hold_asked++;
      if (m == pause_at) drain(0);
      offer(random_item());
    end
  endtask

  task automatic directed_items();
    offer(make_item(FUNC_STILL,  0,  '1, '1, 1'b0));
    offer(make_item(FUNC_STILL,  63, '0, '0, 1'b1));
    offer(make_item(FUNC_ADD,    63, '0, '0, 1'b1));
    offer(make_item(FUNC_REMOVE, 0,  '1, '1, 1'b0));
    // Every event is a parent of event 63, and 63 is the parent of 0, so the rows
    // hold a cycle through 0 and 63 with a short chain 0, 1, 2 hanging off it.
    offer(make_item(FUNC_LOAD,   63, '1, '0, 1'b0));
    offer(make_item(FUNC_LOAD,   0,  64'd1 << 63, '1, 1'b1));
    offer(make_item(FUNC_LOAD,   1,  64'd1, '0, 1'b0));
    offer(make_item(FUNC_LOAD,   2,  64'd2, '0, 1'b0));
    offer(make_item(FUNC_ADD,    2,  '0, '0, 1'b1));
    offer(make_item(FUNC_ADD,    2,  '0, 64'd1 << 40, 1'b0));
    offer(make_item(FUNC_REMOVE, 0,  '0, '1, 1'b1));
    offer(make_item(FUNC_REMOVE, 5,  '0, '1, 1'b0));
    offer(make_item(FUNC_ADD,    0,  '0, 64'h5555_5555_5555_5555, 1'b0));
    offer(make_item(FUNC_REMOVE, 63, '0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
    // A count above the event limit acts as the full width.
    reconfigure(7'd127);
    offer(make_item(FUNC_STILL,  0,  '0, '1, 1'b1));
    offer(make_item(FUNC_ADD,    10, '1, '0, 1'b0));
    // A zero count acts as one event; moves of inactive events change no bit themselves.
    reconfigure(7'd0);
    offer(make_item(FUNC_ADD,    5,  '0, '1, 1'b0));
    offer(make_item(FUNC_REMOVE, 40, '0, '1, 1'b1));
    offer(make_item(FUNC_STILL,  63, '1, '1, 1'b0));
    reconfigure(7'd1);
    offer(make_item(FUNC_REMOVE, 0,  '0, '1, 1'b0));
    // With three events the stored edge from event 63 into event 0 is masked off.
    reconfigure(7'd3);
    offer(make_item(FUNC_ADD,    2,  '0, '0, 1'b1));
    offer(make_item(FUNC_REMOVE, 0,  '0, 64'd7, 1'b0));
  endtask

  initial begin : stimulus
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= ActReset;
    in_ch.valid           <= 1'b0;
    in_ch.func            <= FUNC_STILL;
    in_ch.event_index     <= '0;
    in_ch.parent_bits     <= '0;
    in_ch.genotype_in     <= '0;
    in_ch.compatible_mode <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items();
    run_phase(7'd64, GRAPH_LAYERED, 45, 1'b0, -1, -1);
    run_phase(ActW'($urandom_range(65, 127)), GRAPH_KEEP, 40, 1'b1, -1, -1);
    run_phase(ActW'($urandom_range(2, 20)), GRAPH_LAYERED, 50, 1'b0, 15, -1);
    run_phase(ActW'($urandom_range(21, 63)), GRAPH_LAYERED, 50, 1'b0, -1, 25);
    // One full-length chain through all 64 events.
    run_phase(7'd64, GRAPH_CHAIN, 8, 1'b1, -1, -1);
    run_phase(ActW'($urandom_range(2, 63)), GRAPH_TANGLED, 40, 1'b0, -1, -1);
    run_phase(7'd64, GRAPH_LAYERED, 40, 1'b0, -1, -1);

    drain(TailCycles);
    if (sb.error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // The receiver picks a new stall pattern after a random span; on request it holds
  // off for a long stretch so that the block backs up into its input.
  initial begin : receiver
    int          served;
    int          span;
    int          tick;
    stall_mode_e mode;
    served = 0;
    span   = 0;
    tick   = 0;
    mode   = RX_OPEN;
    forever begin
      if (hold_asked != served) begin
        served++;
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      if (span == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        span = $urandom_range(16, 200);
      end
      span--;
      tick++;
      case (mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 5) == 0);
        default:   out_ch.ready <= (tick % 3 == 0);
      endcase
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.sample_out);
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
sv/pcr_pkg.sv
sv/pcr_if.sv
sv/pcr_sweep.sv
sv/poset_closure_repair_core.sv
dv/tb_closure_pkg.sv
dv/tb_top.sv
